>>> sv/nos_pkg.sv
// Shared constants, types and helper functions of the NPRACH occasion scheduler.
`timescale 1ns / 1ps

package nos_pkg;

    localparam int CLASS_SLOTS = 3;
    localparam int NUM_CLASSES_DEF = 3;

    localparam int SETUP_W = 42;
    localparam int CFG_INDEX_W = $clog2(CLASS_SLOTS);
    localparam int SUBFRAME_W = 32;
    localparam int LEFT_W = 10;
    localparam int TONES_W = 6;
    localparam int TOTAL_W = 8;

    localparam int PERIOD_W = 14;
    localparam int OFFSET_LO = 14;
    localparam int OFFSET_W = 14;
    localparam int REP_LO = 28;
    localparam int REP_W = 8;
    localparam int TONES_LO = 36;

    localparam logic [TONES_W-1:0] MAX_TONES = 6'd48;
    localparam logic [LEFT_W-1:0] MAX_LEFT = 10'd1023;

    typedef struct packed {
        logic [SUBFRAME_W-1:0] subframe;
        logic [CLASS_SLOTS-1:0] class_mask;
        logic [CLASS_SLOTS-1:0] started_mask;
        logic [TONES_W-1:0] tones_zero;
        logic [TONES_W-1:0] tones_one;
        logic [TONES_W-1:0] tones_two;
        logic [TOTAL_W-1:0] tones_total;
    } result_t;

    // Occasion length ceil(5.6 * rep) = (28 * rep + 4) / 5, saturated to the counter width.
    // The divide by five is a multiply by ceil(2^14 / 5); exact for the 13-bit dividend.
    function automatic logic [LEFT_W-1:0] occasion_length(input logic [REP_W-1:0] rep);
        logic [12:0] dividend;
        logic [25:0] product;
        logic [11:0] quotient;
        dividend = 13'(rep) * 13'd28 + 13'd4;
        product = 26'(dividend) * 26'd3277;
        quotient = product[25:14];
        if (quotient > 12'(MAX_LEFT))
            return MAX_LEFT;
        return quotient[LEFT_W-1:0];
    endfunction

    function automatic logic [TONES_W-1:0] clip_tones(input logic [TONES_W-1:0] tones);
        return (tones > MAX_TONES) ? MAX_TONES : tones;
    endfunction

endpackage

>>> sv/nprach_occasion_scheduler.sv
// Top level of the NPRACH occasion scheduler: class state, report logic and output skid stage.
`timescale 1ns / 1ps

// Each input transfer on the in_valid/in_ready channel is one subframe tick. With hold low
// the report describes the current subframe and the counters then advance by one; with hold
// high the same subframe is reported again and nothing moves.
// Each tick produces exactly one report on the out_valid/out_ready channel, in order.
// Throughput is one tick per cycle while in_ready is high: the per-class compare, add and
// length logic sits between the class state registers and the report register. A two-entry
// output stage (report register plus skid register) keeps in_ready high while one report
// waits, so a stalled receiver only backs up the input once both entries are full.
// The configuration port writes one class setup per cycle; the user must write only while
// the block is idle, which the block itself does not enforce. A write restarts that class
// at its offset. A period of zero disables a class. Reset clears the subframe counter, the
// setups, the start flags and the remaining lengths, and empties the output stage; no clearing
// pass is needed, so a tick may be accepted as soon as reset is released.
module nprach_occasion_scheduler #(
    parameter int NUM_CLASSES = nos_pkg::NUM_CLASSES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [nos_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nos_pkg::SETUP_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             hold,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nos_pkg::SUBFRAME_W-1:0]   subframe,
    output logic                             rach_active,
    output logic [nos_pkg::CLASS_SLOTS-1:0]  class_mask,
    output logic [nos_pkg::CLASS_SLOTS-1:0]  started_mask,
    output logic [nos_pkg::TONES_W-1:0]      tones_zero,
    output logic [nos_pkg::TONES_W-1:0]      tones_one,
    output logic [nos_pkg::TONES_W-1:0]      tones_two,
    output logic [nos_pkg::TOTAL_W-1:0]      tones_total
);

    logic                               in_xfer;
    logic                               advance;
    logic [nos_pkg::SUBFRAME_W-1:0]     count_reg;
    logic [nos_pkg::CLASS_SLOTS-1:0]    cls_active;
    logic [nos_pkg::CLASS_SLOTS-1:0]    cls_started;
    logic [nos_pkg::TONES_W-1:0]        cls_tones [nos_pkg::CLASS_SLOTS];
    nos_pkg::result_t                   res_next;
    nos_pkg::result_t                   out_reg;
    nos_pkg::result_t                   skid_reg;
    logic                               out_valid_reg;
    logic                               skid_valid_reg;

    assign in_ready = !skid_valid_reg;
    assign in_xfer = in_valid && in_ready;
    assign advance = !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_xfer && advance)
            count_reg <= count_reg + 1'b1;
    end

    genvar g;
    generate
        for (g = 0; g < nos_pkg::CLASS_SLOTS; g++)
        begin : g_class
            if (g < NUM_CLASSES)
            begin : g_used
                logic [nos_pkg::SETUP_W-1:0]     setup_reg;
                logic                            start_valid_reg;
                logic [nos_pkg::SUBFRAME_W-1:0]  next_start_reg;
                logic [nos_pkg::LEFT_W-1:0]      left_reg;
                logic [nos_pkg::PERIOD_W-1:0]    period;
                logic [nos_pkg::OFFSET_W-1:0]    offset;
                logic [nos_pkg::REP_W-1:0]       rep;
                logic [nos_pkg::TONES_W-1:0]     tones;
                logic                            enabled;
                logic                            cfg_hit;
                logic [nos_pkg::SUBFRAME_W-1:0]  start_now;
                logic                            start;
                logic [nos_pkg::LEFT_W-1:0]      eff;
                logic                            busy;

                assign period = setup_reg[nos_pkg::PERIOD_W-1:0];
                assign offset = setup_reg[nos_pkg::OFFSET_LO +: nos_pkg::OFFSET_W];
                assign rep = setup_reg[nos_pkg::REP_LO +: nos_pkg::REP_W];
                assign tones = setup_reg[nos_pkg::TONES_LO +: nos_pkg::TONES_W];
                assign enabled = (period != '0);
                assign cfg_hit = cfg_wr_en && (cfg_index == nos_pkg::CFG_INDEX_W'(g));

                // The first tick after enabling starts the occasion grid at the offset.
                assign start_now = start_valid_reg ? next_start_reg
                                                   : nos_pkg::SUBFRAME_W'(offset);
                assign start = enabled && (count_reg == start_now);
                assign eff = start ? nos_pkg::occasion_length(rep) : left_reg;
                assign busy = enabled && (eff != '0);

                assign cls_active[g] = busy;
                assign cls_started[g] = busy && start;
                assign cls_tones[g] = busy ? nos_pkg::clip_tones(tones) : '0;

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        setup_reg <= '0;
                        start_valid_reg <= 1'b0;
                        left_reg <= '0;
                    end
                    else if (cfg_hit)
                    begin
                        setup_reg <= cfg_data;
                        start_valid_reg <= 1'b0;
                        left_reg <= '0;
                    end
                    else if (in_xfer)
                    begin
                        start_valid_reg <= enabled;
                        if (!enabled)
                            left_reg <= '0;
                        else if (advance)
                            left_reg <= (eff != '0) ? eff - 1'b1 : '0;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (in_xfer && enabled && !cfg_hit)
                    begin
                        if (start && advance)
                            next_start_reg <= start_now + nos_pkg::SUBFRAME_W'(period);
                        else
                            next_start_reg <= start_now;
                    end
                end
            end
            else
            begin : g_unused
                assign cls_active[g] = 1'b0;
                assign cls_started[g] = 1'b0;
                assign cls_tones[g] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        res_next.subframe = count_reg;
        res_next.class_mask = cls_active;
        res_next.started_mask = cls_started;
        res_next.tones_zero = cls_tones[0];
        res_next.tones_one = cls_tones[1];
        res_next.tones_two = cls_tones[2];
        res_next.tones_total = nos_pkg::TOTAL_W'(cls_tones[0]) + nos_pkg::TOTAL_W'(cls_tones[1])
                             + nos_pkg::TOTAL_W'(cls_tones[2]);
    end

    // The skid register only fills while the report register is stalled; it drains first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_xfer;
        end
        else if (in_xfer)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_xfer)
                out_reg <= res_next;
        end
        else if (in_xfer)
            skid_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign subframe = out_reg.subframe;
    assign class_mask = out_reg.class_mask;
    assign started_mask = out_reg.started_mask;
    assign rach_active = (out_reg.class_mask != '0);
    assign tones_zero = out_reg.tones_zero;
    assign tones_one = out_reg.tones_one;
    assign tones_two = out_reg.tones_two;
    assign tones_total = out_reg.tones_total;

endmodule

>>> sv/nos_checker.sv
// Port-level assertions for the NPRACH occasion scheduler and their bind to the top level.
`timescale 1ns / 1ps

module nos_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [nos_pkg::SUBFRAME_W-1:0]   subframe,
    input logic                             rach_active,
    input logic [nos_pkg::CLASS_SLOTS-1:0]  class_mask,
    input logic [nos_pkg::CLASS_SLOTS-1:0]  started_mask,
    input logic [nos_pkg::TONES_W-1:0]      tones_zero,
    input logic [nos_pkg::TONES_W-1:0]      tones_one,
    input logic [nos_pkg::TONES_W-1:0]      tones_two,
    input logic [nos_pkg::TOTAL_W-1:0]      tones_total
);

    // A stalled report holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(subframe) && $stable(class_mask))
        else $error("stalled report changed");

    a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rach_active == (class_mask != '0))
        else $error("rach_active disagrees with class_mask");

    a_started_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (started_mask & ~class_mask) == '0)
        else $error("occasion started on an unreserved class");

    a_tone_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tones_total == nos_pkg::TOTAL_W'(tones_zero) + nos_pkg::TOTAL_W'(tones_one)
                                     + nos_pkg::TOTAL_W'(tones_two))
        else $error("tone total is not the sum of class tones");

    a_idle_tones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (class_mask[0] || tones_zero == '0) && (class_mask[1] || tones_one == '0)
                      && (class_mask[2] || tones_two == '0))
        else $error("tones reported for an unreserved class");

endmodule

bind nprach_occasion_scheduler nos_checker u_nos_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for the NPRACH occasion scheduler with a built-in occasion predictor.
`timescale 1ns / 1ps

typedef struct {
    logic [nos_pkg::SUBFRAME_W-1:0] subframe;
    logic                           rach_active;
    logic [nos_pkg::CLASS_SLOTS-1:0] class_mask;
    logic [nos_pkg::CLASS_SLOTS-1:0] started_mask;
    logic [nos_pkg::TONES_W-1:0]    tones_zero;
    logic [nos_pkg::TONES_W-1:0]    tones_one;
    logic [nos_pkg::TONES_W-1:0]    tones_two;
    logic [nos_pkg::TOTAL_W-1:0]    tones_total;
} report_t;

class occasion_scoreboard;
    localparam int unsigned TONE_CAP = 48;
    localparam int unsigned SPAN_CAP = 1023;

    logic [nos_pkg::SETUP_W-1:0]    setup [nos_pkg::CLASS_SLOTS];
    logic [nos_pkg::SUBFRAME_W-1:0] subframe_now;
    logic [nos_pkg::SUBFRAME_W-1:0] next_start [nos_pkg::CLASS_SLOTS];
    bit                             start_loaded [nos_pkg::CLASS_SLOTS];
    logic [nos_pkg::LEFT_W-1:0]     span_left [nos_pkg::CLASS_SLOTS];
    report_t                        due_reports [$];
    int                             mismatches;

    function new();
        subframe_now = '0;
        mismatches = 0;
        for (int c = 0; c < nos_pkg::CLASS_SLOTS; c++)
        begin
            setup[c] = '0;
            next_start[c] = '0;
            start_loaded[c] = 1'b0;
            span_left[c] = '0;
        end
    endfunction

    // A setup write restarts the class at its offset on the next tick.
    function void write_setup(int c, logic [nos_pkg::SETUP_W-1:0] value);
        setup[c] = value;
        start_loaded[c] = 1'b0;
        span_left[c] = '0;
    endfunction

    // Occasion length is ceil(5.6 * rep), done exactly as (28 * rep + 4) / 5.
    static function int unsigned reservation_span(int unsigned rep);
        int unsigned span;
        span = (rep * 28 + 4) / 5;
        return (span > SPAN_CAP) ? SPAN_CAP : span;
    endfunction

    function void note_tick(logic hold_tick);
        report_t                      r;
        logic [nos_pkg::PERIOD_W-1:0] period;
        logic [nos_pkg::OFFSET_W-1:0] offset;
        logic [nos_pkg::REP_W-1:0]    rep;
        logic [nos_pkg::TONES_W-1:0]  tones;
        logic [nos_pkg::TONES_W-1:0]  tone_cnt [nos_pkg::CLASS_SLOTS];
        int unsigned                  span;
        logic                         begins;
        r.subframe = subframe_now;
        r.class_mask = '0;
        r.started_mask = '0;
        r.tones_total = '0;
        for (int c = 0; c < nos_pkg::CLASS_SLOTS; c++)
            tone_cnt[c] = '0;
        for (int c = 0; c < nos_pkg::NUM_CLASSES_DEF; c++)
        begin
            period = setup[c][nos_pkg::PERIOD_W-1:0];
            offset = setup[c][nos_pkg::OFFSET_LO +: nos_pkg::OFFSET_W];
            rep = setup[c][nos_pkg::REP_LO +: nos_pkg::REP_W];
            tones = setup[c][nos_pkg::TONES_LO +: nos_pkg::TONES_W];
            if (period == 0)
            begin
                start_loaded[c] = 1'b0;
                span_left[c] = '0;
                continue;
            end
            if (!start_loaded[c])
            begin
                next_start[c] = nos_pkg::SUBFRAME_W'(offset);
                start_loaded[c] = 1'b1;
            end
            begins = (subframe_now == next_start[c]);
            span = begins ? reservation_span(rep) : span_left[c];
            if (span != 0)
            begin
                r.class_mask[c] = 1'b1;
                r.started_mask[c] = begins;
                tone_cnt[c] = (tones > TONE_CAP) ? nos_pkg::TONES_W'(TONE_CAP) : tones;
                r.tones_total = r.tones_total + tone_cnt[c];
            end
            if (!hold_tick)
            begin
                span_left[c] = (span != 0) ? nos_pkg::LEFT_W'(span - 1) : '0;
                if (begins)
                    next_start[c] = next_start[c] + period;
            end
        end
        r.rach_active = |r.class_mask;
        r.tones_zero = tone_cnt[0];
        r.tones_one = tone_cnt[1];
        r.tones_two = tone_cnt[2];
        if (!hold_tick)
            subframe_now = subframe_now + 1;
        due_reports.insert(due_reports.size(), r);
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want,
                       longint unsigned sf);
        if (got != want)
            report_mismatch($sformatf("subframe %0d: %s is %0d, expected %0d",
                                      sf, name, got, want));
    endtask

    task check_report(report_t got);
        report_t want;
        if (due_reports.size() == 0)
        begin
            report_mismatch($sformatf("report for subframe %0d with none pending", got.subframe));
            return;
        end
        want = due_reports.pop_front();
        compare_field("subframe", got.subframe, want.subframe, want.subframe);
        compare_field("rach_active", got.rach_active, want.rach_active, want.subframe);
        compare_field("class_mask", got.class_mask, want.class_mask, want.subframe);
        compare_field("started_mask", got.started_mask, want.started_mask, want.subframe);
        compare_field("tones_zero", got.tones_zero, want.tones_zero, want.subframe);
        compare_field("tones_one", got.tones_one, want.tones_one, want.subframe);
        compare_field("tones_two", got.tones_two, want.tones_two, want.subframe);
        compare_field("tones_total", got.tones_total, want.tones_total, want.subframe);
    endtask
endclass

module tb;

    localparam int CLASS0_SETUP = 0;
    localparam int CLASS1_SETUP = 1;
    localparam int CLASS2_SETUP = 2;
    localparam int PHASES = 8;
    localparam int PHASE_TICKS = 85;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [nos_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [nos_pkg::SETUP_W-1:0]         cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                hold = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [nos_pkg::SUBFRAME_W-1:0]      subframe;
    logic                                rach_active;
    logic [nos_pkg::CLASS_SLOTS-1:0]     class_mask;
    logic [nos_pkg::CLASS_SLOTS-1:0]     started_mask;
    logic [nos_pkg::TONES_W-1:0]         tones_zero;
    logic [nos_pkg::TONES_W-1:0]         tones_one;
    logic [nos_pkg::TONES_W-1:0]         tones_two;
    logic [nos_pkg::TOTAL_W-1:0]         tones_total;

    occasion_scoreboard sb = new();

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   burst_left = 0;
    int   cycles = 0;
    logic holdoff_req = 1'b0;
    logic holdoff_seen = 1'b0;
    int   holdoff_left = 0;

    nprach_occasion_scheduler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .hold         (hold),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .subframe     (subframe),
        .rach_active  (rach_active),
        .class_mask   (class_mask),
        .started_mask (started_mask),
        .tones_zero   (tones_zero),
        .tones_one    (tones_one),
        .tones_two    (tones_two),
        .tones_total  (tones_total)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: checks each output transfer and drives out_ready, including the long hold-off.
    always @(posedge clk)
    begin : receiver
        report_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = '{subframe, rach_active, class_mask, started_mask,
                         tones_zero, tones_one, tones_two, tones_total};
                sb.check_report(seen);
            end
            if (holdoff_req != holdoff_seen)
            begin
                holdoff_seen <= holdoff_req;
                holdoff_left <= HOLDOFF_CYCLES;
                out_ready <= 1'b0;
            end
            else if (holdoff_left > 0)
            begin
                holdoff_left <= holdoff_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [nos_pkg::SETUP_W-1:0] pack_setup(int unsigned period,
                                                               int unsigned offset,
                                                               int unsigned rep,
                                                               int unsigned tones);
        return {nos_pkg::TONES_W'(tones), nos_pkg::REP_W'(rep), nos_pkg::OFFSET_W'(offset),
                nos_pkg::PERIOD_W'(period)};
    endfunction

    // Mostly short periods and offsets just ahead of the counter so occasions really start.
    function automatic logic [nos_pkg::SETUP_W-1:0] random_setup();
        int unsigned period;
        int unsigned offset;
        int unsigned rep;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            period = 0;
        else if (pick < 18)
            period = $urandom_range(16383);
        else
            period = $urandom_range(24, 1);
        pick = $urandom_range(99);
        if (pick < 70)
            offset = sb.subframe_now + $urandom_range(30);
        else if (pick < 85)
            offset = $urandom_range(16383);
        else
            offset = 0;
        pick = $urandom_range(99);
        if (pick < 10)
            rep = 0;
        else if (pick < 20)
            rep = $urandom_range(255);
        else
            rep = $urandom_range(6, 1);
        return pack_setup(period, offset, rep, $urandom_range(63));
    endfunction

    // Leaves cfg_wr_en high so back-to-back writes need one assignment per edge.
    task automatic write_setup(int idx, logic [nos_pkg::SETUP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= nos_pkg::CFG_INDEX_W'(idx);
        cfg_data <= value;
        @(posedge clk);
        sb.write_setup(idx, value);
    endtask

    task automatic send_tick(logic hold_tick);
        in_valid <= 1'b1;
        hold <= hold_tick;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(hold_tick);
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.due_reports.size() != 0);
    endtask

    initial
    begin
        logic [2:0] write_mask;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing configured yet: every class is disabled.
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drained();

        // Overlapping occasions, a long saturated reservation with tones above the cap,
        // and a class with zero repetitions and a one-subframe period that never reserves.
        write_setup(CLASS0_SETUP, pack_setup(4, sb.subframe_now, 1, 12));
        write_setup(CLASS1_SETUP, pack_setup(16383, 3, 255, 63));
        write_setup(CLASS2_SETUP, pack_setup(1, 2, 0, 48));
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 12; i++)
            send_tick(i == 2 || i == 6 || i == 7);
        wait_drained();

        // An offset already behind the counter, and a disabled class with other fields set.
        write_setup(CLASS2_SETUP, pack_setup(2, 0, 3, 5));
        write_setup(CLASS0_SETUP, pack_setup(0, 16383, 7, 20));
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 5; i++)
            send_tick(i == 3);
        wait_drained();

        // All fields at their maximum, and a one-subframe period with zero tones.
        write_setup(CLASS0_SETUP, {nos_pkg::SETUP_W{1'b1}});
        write_setup(CLASS2_SETUP, pack_setup(1, sb.subframe_now + 1, 1, 0));
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 5; i++)
            send_tick(i == 4);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_mask = (p == 0) ? 3'b111 : 3'($urandom_range(7, 1));
            for (int c = 0; c < nos_pkg::CLASS_SLOTS; c++)
                if (write_mask[c])
                    write_setup(c, random_setup());
            cfg_wr_en <= 1'b0;
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                // Stall the receiver for a long stretch while the sender keeps pushing.
                if (p % 2 == 1 && i == 30)
                begin
                    holdoff_req <= ~holdoff_req;
                    burst_left = 16;
                end
                if (p % 3 == 2 && i == 50)
                    wait_drained();
                send_tick($urandom_range(99) < 25);
            end
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
